// File: rtl/core/quad_x_motor_mixer_assert.svh
// ---------------------------------------------------------------------------
// quad_x_motor_mixer_assert.svh
// assertion macros for the motor mixer checker
// ---------------------------------------------------------------------------
`ifndef QUAD_X_MOTOR_MIXER_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define QXMM_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("motor mixer check failed");

// next-cycle implication, checked out of reset
`define QXMM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("motor mixer check failed");

`endif

// File: rtl/core/qxmm_pkg.sv
// ---------------------------------------------------------------------------
// qxmm_pkg
// shared constants for the quad x-frame motor mixer
// ---------------------------------------------------------------------------
package qxmm_pkg;

    // default fixed-point fraction width
    localparam int FRACTION_BITS_DEFAULT = 12;

    // commands carry a sign bit and three integer bits above the fraction
    localparam int CMD_EXTRA_BITS = 4;

    // authority ramp gain and the divisor that places its start at 0.05
    localparam int MIX_GAIN        = 10;
    localparam int MIX_LOW_DIVISOR = 20;

    // number of motors
    localparam int MOTOR_COUNT = 4;

endpackage

// File: rtl/core/qxmm_limit.sv
// ---------------------------------------------------------------------------
// qxmm_limit
// throttle saturation, correction bound and mix authority
// ---------------------------------------------------------------------------
module qxmm_limit #(
    parameter int FRACTION_BITS = qxmm_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic [FRACTION_BITS:0]   throttle,
    output logic [FRACTION_BITS:0]   throttle_sat,
    output logic [FRACTION_BITS-1:0] limit,
    output logic [FRACTION_BITS:0]   authority
);
    import qxmm_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam int PW = FB + 5;
    localparam logic [FB:0]   ONE  = (FB + 1)'(1) << FB;
    localparam logic [FB:0]   HALF = ONE >> 1;
    localparam logic [FB:0]   LOW  =
        (FB + 1)'(((1 << FB) + MIX_LOW_DIVISOR / 2) / MIX_LOW_DIVISOR);
    localparam logic [PW-1:0] ONE_WIDE = PW'(ONE);

    logic [FB:0]   thr;
    logic [FB:0]   headroom;
    logic [FB:0]   bound;
    logic [FB:0]   ramp_base;
    logic [PW-1:0] ramp;

    // throttle above full counts as full
    always_comb
    begin
        thr = (throttle > ONE) ? ONE : throttle;
    end

    // bound = min(half, thr, one - thr)
    always_comb
    begin
        headroom = ONE - thr;
        bound    = HALF;
        if (thr < bound)
        begin
            bound = thr;
        end
        if (headroom < bound)
        begin
            bound = headroom;
        end
    end

    // authority ramp (thr - low) * gain, clamped to 0..one
    always_comb
    begin
        ramp_base = (thr > LOW) ? (thr - LOW) : '0;
        ramp      = PW'(ramp_base) * PW'(MIX_GAIN);
        authority = (ramp > ONE_WIDE) ? ONE : ramp[FB:0];
    end

    assign throttle_sat = thr;
    assign limit        = bound[FB-1:0];

endmodule

// File: rtl/core/qxmm_motor.sv
// ---------------------------------------------------------------------------
// qxmm_motor
// one motor lane: signed sum, clamp, authority scaling and drive output
// ---------------------------------------------------------------------------
module qxmm_motor #(
    parameter int FRACTION_BITS = qxmm_pkg::FRACTION_BITS_DEFAULT,
    parameter bit PITCH_NEG     = 1'b0,
    parameter bit ROLL_NEG      = 1'b0
) (
    input  logic [FRACTION_BITS:0]                              throttle_sat,
    input  logic signed [FRACTION_BITS+qxmm_pkg::CMD_EXTRA_BITS-1:0] roll_command,
    input  logic signed [FRACTION_BITS+qxmm_pkg::CMD_EXTRA_BITS-1:0] pitch_command,
    input  logic [FRACTION_BITS-1:0]                            limit,
    input  logic [FRACTION_BITS:0]                              authority,
    output logic [FRACTION_BITS:0]                              motor,
    output logic                                                saturated
);
    import qxmm_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam int CW = FB + CMD_EXTRA_BITS;
    localparam int RW = CW + 2;
    localparam int MW = 2 * FB + 4;
    localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

    logic signed [RW-1:0]   pitch_term;
    logic signed [RW-1:0]   roll_term;
    logic signed [RW-1:0]   raw;
    logic signed [RW-1:0]   raw_mag;
    logic signed [RW-1:0]   lim_pos;
    logic signed [RW-1:0]   clamped;
    logic signed [FB+1:0]   clamped_short;
    logic signed [FB+1:0]   auth_s;
    logic signed [MW-1:0]   product;
    logic signed [MW-1:0]   scaled;
    logic signed [FB+2:0]   drive_sum;

    // raw correction with this lane's signs
    always_comb
    begin
        pitch_term = RW'(pitch_command);
        roll_term  = RW'(roll_command);
        if (PITCH_NEG)
        begin
            pitch_term = -pitch_term;
        end
        if (ROLL_NEG)
        begin
            roll_term = -roll_term;
        end
        raw = pitch_term + roll_term;
    end

    // saturation flag and clamp to +-limit
    always_comb
    begin
        lim_pos   = $signed(RW'(limit));
        raw_mag   = raw[RW-1] ? -raw : raw;
        saturated = (raw_mag > lim_pos);
        if (raw > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (raw < -lim_pos)
        begin
            clamped = -lim_pos;
        end
        else
        begin
            clamped = raw;
        end
        clamped_short = clamped[FB+1:0];
    end

    // scale by authority, floor shift back to fraction
    always_comb
    begin
        auth_s  = $signed({1'b0, authority});
        product = MW'(clamped_short) * MW'(auth_s);
        scaled  = product >>> FB;
    end

    // drive = throttle + correction, kept in 0..one
    always_comb
    begin
        drive_sum = $signed({2'b00, throttle_sat}) + (FB + 3)'($signed(scaled[FB+1:0]));
        if (drive_sum[FB+2])
        begin
            motor = '0;
        end
        else if (drive_sum[FB+1:0] > (FB + 2)'(ONE))
        begin
            motor = ONE;
        end
        else
        begin
            motor = drive_sum[FB:0];
        end
    end

endmodule

// File: rtl/core/quad_x_motor_mixer.sv
// ---------------------------------------------------------------------------
// quad_x_motor_mixer
// quad x-frame motor mixer: throttle, roll and pitch into four motor drives
// ---------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   throttle, roll_command, pitch_command
//  out      out_valid / out_stall motor_one..motor_four, correction_limit,
//                                 saturated_mask
//
//  one transaction per cycle sustained while out_stall is low; path: input register,
//  then the mixing logic and its four multipliers into the result register
//  reset clears both stage valid flags; payload registers are not reset
//  out_stall holds the result; the input register keeps accepting while the
//  result register is empty or being drained, so in_stall rises only when
//  both stages hold a transaction and out_stall is high
// ---------------------------------------------------------------------------
module quad_x_motor_mixer #(
    parameter int FRACTION_BITS = qxmm_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic                                                     in_valid,
    output logic                                                     in_stall,
    input  logic [FRACTION_BITS:0]                                   throttle,
    input  logic signed [FRACTION_BITS+qxmm_pkg::CMD_EXTRA_BITS-1:0] roll_command,
    input  logic signed [FRACTION_BITS+qxmm_pkg::CMD_EXTRA_BITS-1:0] pitch_command,
    output logic                                                     out_valid,
    input  logic                                                     out_stall,
    output logic [FRACTION_BITS:0]                                   motor_one,
    output logic [FRACTION_BITS:0]                                   motor_two,
    output logic [FRACTION_BITS:0]                                   motor_three,
    output logic [FRACTION_BITS:0]                                   motor_four,
    output logic [FRACTION_BITS-1:0]                                 correction_limit,
    output logic [qxmm_pkg::MOTOR_COUNT-1:0]                         saturated_mask
);
    import qxmm_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam int CW = FB + CMD_EXTRA_BITS;

    // input stage
    logic                 in_valid_reg;
    logic [FB:0]          thr_reg;
    logic signed [CW-1:0] roll_reg;
    logic signed [CW-1:0] pitch_reg;

    // mixing results
    logic [FB:0]            thr_sat;
    logic [FB-1:0]          lim;
    logic [FB:0]            auth;
    logic [FB:0]            mix_motor [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] mix_sat;

    // result stage
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [FB:0]            motor_reg [MOTOR_COUNT];
    logic [FB-1:0]          limit_reg;
    logic [MOTOR_COUNT-1:0] sat_reg;

    logic out_advance;
    logic in_load;

    // flow control
    assign out_advance    = !out_valid_reg || !out_stall;
    assign in_stall       = in_valid_reg && !out_advance;
    assign in_load        = !in_stall;
    assign out_valid_next = out_advance ? in_valid_reg : out_valid_reg;

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            thr_reg   <= throttle;
            roll_reg  <= roll_command;
            pitch_reg <= pitch_command;
        end
    end

    // bound and authority
    qxmm_limit #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_limit (
        .throttle     (thr_reg),
        .throttle_sat (thr_sat),
        .limit        (lim),
        .authority    (auth)
    );

    // motor lanes: 1 +p+r, 2 -p-r, 3 +p-r, 4 -p+r
    qxmm_motor #(
        .FRACTION_BITS (FRACTION_BITS),
        .PITCH_NEG     (1'b0),
        .ROLL_NEG      (1'b0)
    ) u_motor_one (
        .throttle_sat  (thr_sat),
        .roll_command  (roll_reg),
        .pitch_command (pitch_reg),
        .limit         (lim),
        .authority     (auth),
        .motor         (mix_motor[0]),
        .saturated     (mix_sat[0])
    );

    qxmm_motor #(
        .FRACTION_BITS (FRACTION_BITS),
        .PITCH_NEG     (1'b1),
        .ROLL_NEG      (1'b1)
    ) u_motor_two (
        .throttle_sat  (thr_sat),
        .roll_command  (roll_reg),
        .pitch_command (pitch_reg),
        .limit         (lim),
        .authority     (auth),
        .motor         (mix_motor[1]),
        .saturated     (mix_sat[1])
    );

    qxmm_motor #(
        .FRACTION_BITS (FRACTION_BITS),
        .PITCH_NEG     (1'b0),
        .ROLL_NEG      (1'b1)
    ) u_motor_three (
        .throttle_sat  (thr_sat),
        .roll_command  (roll_reg),
        .pitch_command (pitch_reg),
        .limit         (lim),
        .authority     (auth),
        .motor         (mix_motor[2]),
        .saturated     (mix_sat[2])
    );

    qxmm_motor #(
        .FRACTION_BITS (FRACTION_BITS),
        .PITCH_NEG     (1'b1),
        .ROLL_NEG      (1'b0)
    ) u_motor_four (
        .throttle_sat  (thr_sat),
        .roll_command  (roll_reg),
        .pitch_command (pitch_reg),
        .limit         (lim),
        .authority     (auth),
        .motor         (mix_motor[3]),
        .saturated     (mix_sat[3])
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                motor_reg[i] <= mix_motor[i];
            end
            limit_reg <= lim;
            sat_reg   <= mix_sat;
        end
    end

    // outputs
    assign out_valid        = out_valid_reg;
    assign motor_one        = motor_reg[0];
    assign motor_two        = motor_reg[1];
    assign motor_three      = motor_reg[2];
    assign motor_four       = motor_reg[3];
    assign correction_limit = limit_reg;
    assign saturated_mask   = sat_reg;

endmodule

// File: rtl/core/qxmm_checker.sv
// ---------------------------------------------------------------------------
// qxmm_checker
// port-level checks for the motor mixer, bound to the top level
// ---------------------------------------------------------------------------
`include "quad_x_motor_mixer_assert.svh"

module qxmm_checker #(
    parameter int FRACTION_BITS = qxmm_pkg::FRACTION_BITS_DEFAULT
) (
    input logic                                                     clk,
    input logic                                                     rst_n,
    input logic                                                     in_valid,
    input logic                                                     in_stall,
    input logic [FRACTION_BITS:0]                                   throttle,
    input logic signed [FRACTION_BITS+qxmm_pkg::CMD_EXTRA_BITS-1:0] roll_command,
    input logic signed [FRACTION_BITS+qxmm_pkg::CMD_EXTRA_BITS-1:0] pitch_command,
    input logic                                                     out_valid,
    input logic                                                     out_stall,
    input logic [FRACTION_BITS:0]                                   motor_one,
    input logic [FRACTION_BITS:0]                                   motor_two,
    input logic [FRACTION_BITS:0]                                   motor_three,
    input logic [FRACTION_BITS:0]                                   motor_four,
    input logic [FRACTION_BITS-1:0]                                 correction_limit,
    input logic [qxmm_pkg::MOTOR_COUNT-1:0]                         saturated_mask
);
    import qxmm_pkg::*;

    localparam logic [FRACTION_BITS:0]   ONE  = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
    localparam logic [FRACTION_BITS-1:0] HALF = FRACTION_BITS'(1) << (FRACTION_BITS - 1);

    // input back-pressure only comes from a held result
    `QXMM_ASSERT_NOW(a_stall_only_when_blocked, clk, rst_n, in_stall,
                     out_valid && out_stall)

    // stalled input transaction stays put
    `QXMM_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
                      in_valid && $stable(throttle) && $stable(roll_command) &&
                      $stable(pitch_command))

    // bound never exceeds half and drives stay in range
    `QXMM_ASSERT_NOW(a_range, clk, rst_n, out_valid,
                     correction_limit <= HALF && motor_one <= ONE && motor_two <= ONE &&
                     motor_three <= ONE && motor_four <= ONE)

    // zero bound means no correction on any motor
    `QXMM_ASSERT_NOW(a_zero_bound_flat, clk, rst_n, out_valid && correction_limit == '0,
                     motor_one == motor_two && motor_two == motor_three &&
                     motor_three == motor_four)

    // held result stays put: motors one and four, the bound and the mask
    `QXMM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
                      out_valid && $stable(motor_one) && $stable(motor_four) &&
                      $stable(correction_limit) && $stable(saturated_mask))

endmodule

bind quad_x_motor_mixer qxmm_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_qxmm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .throttle         (throttle),
    .roll_command     (roll_command),
    .pitch_command    (pitch_command),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .motor_one        (motor_one),
    .motor_two        (motor_two),
    .motor_three      (motor_three),
    .motor_four       (motor_four),
    .correction_limit (correction_limit),
    .saturated_mask   (saturated_mask)
);

// File: bench/quad_x_motor_mixer_tb.sv
// ---------------------------------------------------------------------------
// quad_x_motor_mixer_tb
// self-checking bench for the quad x-frame motor mixer: a directed table of
// command sets, some with hand-worked drives, then random command sets
// checked against an independent mixing predictor, with random idle and
// stall bursts on both channels
// ---------------------------------------------------------------------------
module quad_x_motor_mixer_tb;

    localparam int FB          = qxmm_pkg::FRACTION_BITS_DEFAULT;
    localparam int CW          = FB + qxmm_pkg::CMD_EXTRA_BITS;
    localparam int MC          = qxmm_pkg::MOTOR_COUNT;
    localparam int RANDOM_SETS = 650;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ROW_COUNT   = 20;

    typedef struct packed {
        logic [FB:0]   motor_one;
        logic [FB:0]   motor_two;
        logic [FB:0]   motor_three;
        logic [FB:0]   motor_four;
        logic [FB-1:0] correction_limit;
        logic [MC-1:0] saturated_mask;
    } drive_set_t;

    typedef struct packed {
        logic [FB:0]          throttle;
        logic signed [CW-1:0] roll;
        logic signed [CW-1:0] pitch;
        logic                 hand_checked;
        drive_set_t           want;
    } mix_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [FB:0]          throttle = '0;
    logic signed [CW-1:0] roll_command = '0;
    logic signed [CW-1:0] pitch_command = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [FB:0]          motor_one;
    logic [FB:0]          motor_two;
    logic [FB:0]          motor_three;
    logic [FB:0]          motor_four;
    logic [FB-1:0]        correction_limit;
    logic [MC-1:0]        saturated_mask;

    drive_set_t drive_sets_due[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         idle_pct = 0;
    int         stall_left = 0;

    // directed command sets; hand-worked drives where they are obvious
    mix_row_t directed_rows [0:ROW_COUNT-1] = '{
        // zero throttle, no command
        '{13'd0, 16'sd0, 16'sd0, 1'b1, '{13'd0, 13'd0, 13'd0, 13'd0, 12'd0, 4'h0}},
        // zero bound, any command saturates
        '{13'd0, 16'sd1, 16'sd0, 1'b1, '{13'd0, 13'd0, 13'd0, 13'd0, 12'd0, 4'hF}},
        // throttle field all ones, clipped to full
        '{13'h1FFF, 16'sd0, 16'sd0, 1'b1,
          '{13'd4096, 13'd4096, 13'd4096, 13'd4096, 12'd0, 4'h0}},
        // full throttle, command extremes
        '{13'd4096, 16'h7FFF, 16'h8000, 1'b1,
          '{13'd4096, 13'd4096, 13'd4096, 13'd4096, 12'd0, 4'hF}},
        // just above full, equal negative extremes cancel on two motors
        '{13'd4097, 16'h8000, 16'h8000, 1'b1,
          '{13'd4096, 13'd4096, 13'd4096, 13'd4096, 12'd0, 4'h3}},
        // mid throttle, widest bound
        '{13'd2048, 16'sd0, 16'sd0, 1'b1,
          '{13'd2048, 13'd2048, 13'd2048, 13'd2048, 12'd2048, 4'h0}},
        // pitch exactly at the bound
        '{13'd2048, 16'sd0, 16'sd2048, 1'b1,
          '{13'd4096, 13'd0, 13'd4096, 13'd0, 12'd2048, 4'h0}},
        // pitch one past the bound
        '{13'd2048, 16'sd0, 16'sd2049, 1'b1,
          '{13'd4096, 13'd0, 13'd4096, 13'd0, 12'd2048, 4'hF}},
        // roll one past the bound
        '{13'd2048, 16'sd2049, 16'sd0, 1'b1,
          '{13'd4096, 13'd0, 13'd0, 13'd4096, 12'd2048, 4'hF}},
        // tiny authority, negative product rounds toward minus infinity
        '{13'd206, 16'hFFFF, 16'sd0, 1'b1,
          '{13'd205, 13'd206, 13'd206, 13'd205, 12'd206, 4'h0}},
        // ramp start, no authority
        '{13'd205, 16'sd100, 16'sd100, 1'b1,
          '{13'd205, 13'd205, 13'd205, 13'd205, 12'd205, 4'h0}},
        '{13'd205, 16'h7FFF, 16'h7FFF, 1'b0, '0},
        // ramp top, just below and just at full authority
        '{13'd614, 16'sd300, -16'sd200, 1'b0, '0},
        '{13'd615, -16'sd614, 16'sd1, 1'b0, '0},
        '{13'd3000, 16'h8000, 16'h7FFF, 1'b0, '0},
        // smallest nonzero bounds at both ends
        '{13'd4095, 16'sd1, 16'sd1, 1'b0, '0},
        '{13'd1, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{13'd2047, 16'sd1024, 16'sd1023, 1'b0, '0},
        '{13'd3072, -16'sd2000, 16'sd500, 1'b0, '0},
        // above full with a large command
        '{13'd6000, 16'sd12345, -16'sd54, 1'b1,
          '{13'd4096, 13'd4096, 13'd4096, 13'd4096, 12'd0, 4'hF}}
    };

    quad_x_motor_mixer #(
        .FRACTION_BITS(FB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .throttle(throttle),
        .roll_command(roll_command),
        .pitch_command(pitch_command),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .motor_one(motor_one),
        .motor_two(motor_two),
        .motor_three(motor_three),
        .motor_four(motor_four),
        .correction_limit(correction_limit),
        .saturated_mask(saturated_mask)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // predicted motor drives for one command set
    function automatic drive_set_t mix_drives(input logic [FB:0] thr_in,
                                              input logic signed [CW-1:0] roll,
                                              input logic signed [CW-1:0] pitch);
        longint     one;
        longint     ramp_low;
        longint     thr;
        longint     bound;
        longint     auth;
        longint     clipped;
        longint     corr;
        longint     drive;
        longint     mag;
        longint     raw [MC];
        longint     drv [MC];
        drive_set_t d;
        int         k;
        one      = longint'(1) << FB;
        ramp_low = (one + qxmm_pkg::MIX_LOW_DIVISOR / 2) / qxmm_pkg::MIX_LOW_DIVISOR;
        thr      = longint'(thr_in);
        if (thr > one)
            thr = one;
        // bound is min(half, thr, full - thr)
        bound = one / 2;
        if (thr < bound)
            bound = thr;
        if (one - thr < bound)
            bound = one - thr;
        // authority ramp
        auth = (thr - ramp_low) * qxmm_pkg::MIX_GAIN;
        if (auth < 0)
            auth = 0;
        if (auth > one)
            auth = one;
        // x-frame signs per motor
        raw[0] = longint'(pitch) + longint'(roll);
        raw[1] = -longint'(pitch) - longint'(roll);
        raw[2] = longint'(pitch) - longint'(roll);
        raw[3] = -longint'(pitch) + longint'(roll);
        d.saturated_mask = '0;
        for (k = 0; k < MC; k++)
        begin
            clipped = raw[k];
            if (clipped > bound)
                clipped = bound;
            if (clipped < -bound)
                clipped = -bound;
            corr  = (clipped * auth) >>> FB;
            drive = thr + corr;
            if (drive < 0)
                drive = 0;
            if (drive > one)
                drive = one;
            drv[k] = drive;
            mag    = raw[k] < 0 ? -raw[k] : raw[k];
            if (mag > bound)
                d.saturated_mask[k] = 1'b1;
        end
        d.motor_one        = drv[0][FB:0];
        d.motor_two        = drv[1][FB:0];
        d.motor_three      = drv[2][FB:0];
        d.motor_four       = drv[3][FB:0];
        d.correction_limit = bound[FB-1:0];
        return d;
    endfunction

    // present one command set and log its drives once accepted
    task automatic send_command(input logic [FB:0] thr,
                                input logic signed [CW-1:0] roll,
                                input logic signed [CW-1:0] pitch,
                                input logic hand_checked,
                                input drive_set_t hand_want);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        throttle      <= thr;
        roll_command  <= roll;
        pitch_command <= pitch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        drive_sets_due.push_back(hand_checked ? hand_want : mix_drives(thr, roll, pitch));
    endtask

    // result side stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            stall_left = $urandom_range(1, 5);
        out_stall <= (stall_left > 0);
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        drive_set_t got;
        drive_set_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{motor_one, motor_two, motor_three, motor_four,
                    correction_limit, saturated_mask};
            if (drive_sets_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: m1=%0d m2=%0d m3=%0d m4=%0d lim=%0d sat=%h",
                             got.motor_one, got.motor_two, got.motor_three,
                             got.motor_four, got.correction_limit, got.saturated_mask);
            end
            else
            begin
                want = drive_sets_due.pop_front();
                if (got.motor_one != want.motor_one || got.motor_two != want.motor_two ||
                    got.motor_three != want.motor_three ||
                    got.motor_four != want.motor_four ||
                    got.correction_limit != want.correction_limit ||
                    got.saturated_mask != want.saturated_mask)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch expected: m1=%0d m2=%0d m3=%0d m4=%0d lim=%0d sat=%h",
                                 want.motor_one, want.motor_two, want.motor_three,
                                 want.motor_four, want.correction_limit,
                                 want.saturated_mask);
                        $display("         actual:   m1=%0d m2=%0d m3=%0d m4=%0d lim=%0d sat=%h",
                                 got.motor_one, got.motor_two, got.motor_three,
                                 got.motor_four, got.correction_limit,
                                 got.saturated_mask);
                    end
                end
            end
        end
    end

    // reset, directed table, random command sets, drain
    initial
    begin
        logic [FB:0]          thr;
        logic signed [CW-1:0] roll;
        logic signed [CW-1:0] pitch;
        int                   bound;
        int                   i;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 25;
        for (i = 0; i < ROW_COUNT; i++)
            send_command(directed_rows[i].throttle, directed_rows[i].roll,
                         directed_rows[i].pitch, directed_rows[i].hand_checked,
                         directed_rows[i].want);

        for (i = 0; i < RANDOM_SETS; i++)
        begin
            // busy phases with a calm stretch in between and a calm tail
            if (i < 250)
                idle_pct = 30;
            else if (i < 350)
                idle_pct = 0;
            else if (i < RANDOM_SETS - 60)
                idle_pct = 20;
            else
                idle_pct = 0;

            case ($urandom_range(0, 5))
                0:       thr = (FB + 1)'($urandom_range(0, 8191));
                1:       thr = (FB + 1)'($urandom_range(0, 320));
                2:       thr = (FB + 1)'($urandom_range(3900, 4200));
                3:       thr = (FB + 1)'($urandom_range(560, 680));
                default: thr = (FB + 1)'($urandom_range(0, 4096));
            endcase
            case ($urandom_range(0, 3))
                0:       roll = CW'($urandom);
                1:       roll = CW'($urandom_range(0, 8000) - 4000);
                default: roll = CW'($urandom_range(0, 1200) - 600);
            endcase
            case ($urandom_range(0, 3))
                0:       pitch = CW'($urandom);
                1:       pitch = CW'($urandom_range(0, 8000) - 4000);
                default: pitch = CW'($urandom_range(0, 1200) - 600);
            endcase
            // sometimes land motor one at or one step beside its bound
            if ($urandom_range(0, 5) == 0)
            begin
                bound = (thr > 4096) ? 0 : int'(thr);
                if (bound > 2048)
                    bound = 2048;
                if (thr <= 4096 && 4096 - int'(thr) < bound)
                    bound = 4096 - int'(thr);
                if ($urandom_range(0, 1) == 1)
                    bound = -bound;
                pitch = CW'(bound - int'(roll) + int'($urandom_range(0, 2)) - 1);
            end
            send_command(thr, roll, pitch, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (drive_sets_due.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/qxmm_pkg.sv
rtl/core/qxmm_limit.sv
rtl/core/qxmm_motor.sv
rtl/core/quad_x_motor_mixer.sv
rtl/core/qxmm_checker.sv
bench/quad_x_motor_mixer_tb.sv
